@@ rtl/c8tfp_pkg.sv @@
// ----------------------------------------------------------------------------
// c8tfp_pkg
// Shared types, constants and the crc-8 step function for the three frame
// packer.
// ----------------------------------------------------------------------------
package c8tfp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned FRAME_W  = 2;
   localparam int unsigned POS_W    = 3;
   localparam int unsigned INDEX_W  = 5;

   localparam logic [INDEX_W-1:0] BLOCK_LAST  = 5'd16;
   localparam logic [INDEX_W-1:0] FRAME1_BASE = 5'd7;
   localparam logic [INDEX_W-1:0] FRAME2_BASE = 5'd14;

   localparam logic [BYTE_W-1:0]  CRC_POLY  = 8'h07;
   localparam logic [BYTE_W-1:0]  HDR_BASE  = 8'h11;
   localparam logic [BYTE_W-1:0]  PAD_BYTE  = 8'h00;

   localparam logic [FRAME_W-1:0] FRAME_0 = 2'd0;
   localparam logic [FRAME_W-1:0] FRAME_1 = 2'd1;
   localparam logic [FRAME_W-1:0] FRAME_2 = 2'd2;

   localparam logic [POS_W-1:0]   POS_HDR = 3'd0;
   localparam logic [POS_W-1:0]   POS_CRC = 3'd7;

   // step through the results of one transaction
   typedef enum logic [2:0] {
      SEQ_HDR  = 3'd0,
      SEQ_DATA = 3'd1,
      SEQ_PAD0 = 3'd2,
      SEQ_PAD1 = 3'd3,
      SEQ_PAD2 = 3'd4,
      SEQ_CRC  = 3'd5
   } seq_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic [FRAME_W-1:0] frame;
      logic [POS_W-1:0]   pos;
      logic               hdr;
      logic               tail;
      logic [BYTE_W-1:0]  crc;
   } item_type;

   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/c8tfp_emit.sv @@
// ----------------------------------------------------------------------------
// c8tfp_emit
// Holds one decoded transaction and plays out its frame bytes (header,
// payload byte, pad bytes, crc) into the result register.
// ----------------------------------------------------------------------------
module c8tfp_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  c8tfp_pkg::item_type        item,
   output logic                       item_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [c8tfp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [c8tfp_pkg::FRAME_W-1:0] rsp_frame_number,
   output logic [c8tfp_pkg::POS_W-1:0]   rsp_byte_position,
   output logic                       rsp_run_last
);
   import c8tfp_pkg::*;

   logic              hold_valid_ff;
   item_type          hold_ff;
   seq_type           seq_ff;
   seq_type           seq_in;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              last_ff;

   logic              out_load;
   logic              emit;
   logic              is_last;
   logic              take_item;
   logic [BYTE_W-1:0] byte_in;
   logic [FRAME_W-1:0] frame_in;
   logic [POS_W-1:0]  pos_in;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = hold_valid_ff && out_load;
   assign is_last   = (seq_ff == SEQ_DATA && !hold_ff.tail) || (seq_ff == SEQ_CRC);
   assign take_item = !hold_valid_ff || (emit && is_last);
   assign item_stall = !take_item;
   assign seq_in    = seq_type'(3'(seq_ff + 3'd1));

   always_comb begin
      byte_in  = PAD_BYTE;
      frame_in = FRAME_2;
      pos_in   = POS_HDR;
      unique case (seq_ff)
         SEQ_HDR: begin
            byte_in  = HDR_BASE + BYTE_W'(hold_ff.frame);
            frame_in = hold_ff.frame;
            pos_in   = POS_HDR;
         end
         SEQ_DATA: begin
            byte_in  = hold_ff.data;
            frame_in = hold_ff.frame;
            pos_in   = hold_ff.pos;
         end
         SEQ_PAD0, SEQ_PAD1, SEQ_PAD2: begin
            // pad bytes sit at positions 4..6 of frame 2
            byte_in  = PAD_BYTE;
            frame_in = FRAME_2;
            pos_in   = 3'(seq_ff + 3'd2);
         end
         SEQ_CRC: begin
            byte_in  = hold_ff.crc;
            frame_in = FRAME_2;
            pos_in   = POS_CRC;
         end
         default: begin
            byte_in  = PAD_BYTE;
            frame_in = FRAME_2;
            pos_in   = POS_HDR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         seq_ff        <= SEQ_HDR;
      end else if (take_item) begin
         hold_valid_ff <= item_valid;
         if (item_valid) begin
            seq_ff <= item.hdr ? SEQ_HDR : SEQ_DATA;
         end
      end else if (emit) begin
         seq_ff <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_item && item_valid) begin
         hold_ff <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff  <= byte_in;
         frame_ff <= frame_in;
         pos_ff   <= pos_in;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_frame_number  = frame_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_run_last      = last_ff;

endmodule

@@ rtl/crc8_three_frame_packer.sv @@
// ----------------------------------------------------------------------------
// crc8_three_frame_packer
// Packs 17-byte payload blocks into three 8-byte frames with headers, zero
// pad and a crc-8 (poly 0x07) over the payload.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid, req_stall, req_data_byte     | in (stall out)
//  rsp     | rsp_valid, rsp_stall, rsp_out_byte,     | out (stall in)
//          | rsp_frame_number, rsp_byte_position,    |
//          | rsp_run_last                            |
//
// one result leaves per cycle while a result is held and rsp_stall is low;
// most bytes give one result, bytes 0, 7 and 14 give two (header first) and
// byte 16 gives five, so a block of 17 bytes gives 24 results.
// a taken transaction is held in the emitter, then its results are registered.
// synchronous reset clears the block position, the crc and both valids.
// rsp_stall holds the result register; the next transaction is taken as
// soon as the held one hands over its last result.
// ----------------------------------------------------------------------------
module crc8_three_frame_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [c8tfp_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [c8tfp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [c8tfp_pkg::FRAME_W-1:0] rsp_frame_number,
   output logic [c8tfp_pkg::POS_W-1:0]   rsp_byte_position,
   output logic                          rsp_run_last
);
   import c8tfp_pkg::*;

   logic [INDEX_W-1:0] index_ff;
   logic [INDEX_W-1:0] index_in;
   logic [BYTE_W-1:0]  crc_ff;
   logic [BYTE_W-1:0]  crc_in;

   logic               accept;
   logic               item_stall;
   logic [INDEX_W-1:0] p;
   logic [BYTE_W-1:0]  crc_base;
   logic [BYTE_W-1:0]  crc_next;
   item_type           item;

   assign req_stall = item_stall;
   assign accept    = req_valid && !item_stall;

   always_comb begin
      // an index past the block end restarts the block
      if (index_ff > BLOCK_LAST) begin
         p        = '0;
         crc_base = '0;
      end else begin
         p        = index_ff;
         crc_base = crc_ff;
      end
      crc_next = crc8_update(crc_base, req_data_byte);

      item.data = req_data_byte;
      item.crc  = crc_next;
      item.tail = (p == BLOCK_LAST);
      if (p < FRAME1_BASE) begin
         item.frame = FRAME_0;
         item.pos   = POS_W'(p + 5'd1);
      end else if (p < FRAME2_BASE) begin
         item.frame = FRAME_1;
         item.pos   = POS_W'(p - 5'd6);
      end else begin
         item.frame = FRAME_2;
         item.pos   = POS_W'(p - 5'd13);
      end
      item.hdr = (item.pos == 3'd1);

      if (p == BLOCK_LAST) begin
         index_in = '0;
         crc_in   = '0;
      end else begin
         index_in = INDEX_W'(p + 5'd1);
         crc_in   = crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         crc_ff   <= '0;
      end else if (accept) begin
         index_ff <= index_in;
         crc_ff   <= crc_in;
      end
   end

   c8tfp_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (req_valid),
      .item              (item),
      .item_stall        (item_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_byte_position (rsp_byte_position),
      .rsp_run_last      (rsp_run_last)
   );

endmodule
